// ===== rtl/core/hrhp_pkg.sv =====
// Package: transaction types, character codes and match tables for the request head parser
`default_nettype none

package hrhp_pkg;

    // Input transaction: one request byte
    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_request;
    } hrhp_in_t;

    // Output transaction: one verdict per byte
    typedef struct packed {
        logic [1:0] verdict;
        logic       host_valid;
        logic [7:0] host_byte;
    } hrhp_out_t;

    // Verdict codes
    localparam logic [1:0] VERDICT_INCOMPLETE = 2'd0;
    localparam logic [1:0] VERDICT_GET        = 2'd1;
    localparam logic [1:0] VERDICT_BAD        = 2'd2;
    localparam logic [1:0] VERDICT_OVERFLOW   = 2'd3;

    // Line substates, request line
    localparam logic [3:0] SUB_METHOD   = 4'd0;
    localparam logic [3:0] SUB_SKIP1    = 4'd1;
    localparam logic [3:0] SUB_URL      = 4'd2;
    localparam logic [3:0] SUB_SKIP2    = 4'd3;
    localparam logic [3:0] SUB_VERSION  = 4'd4;
    // Line substates, header lines
    localparam logic [3:0] SUB_START    = 4'd0;
    localparam logic [3:0] SUB_PREFIX   = 4'd5;
    localparam logic [3:0] SUB_HOSTSKIP = 4'd6;
    localparam logic [3:0] SUB_HOSTVAL  = 4'd7;
    localparam logic [3:0] SUB_OTHER    = 4'd8;

    // Phase codes
    localparam logic PHASE_REQUEST = 1'b0;
    localparam logic PHASE_HEADER  = 1'b1;

    // Characters
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    // Match lengths
    localparam logic [3:0] METHOD_LEN  = 4'd3;
    localparam logic [3:0] VERSION_LEN = 4'd8;
    localparam logic [3:0] HOST_LEN    = 4'd5;

    // Size limit after reset
    localparam logic [15:0] MAX_BYTES_RESET = 16'd4096;

    // Fold upper case letters to lower case
    function automatic logic [7:0] lower_of(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
            return c + 8'd32;
        return c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SP) || (c == CHAR_TAB);
    endfunction

    // "get"
    function automatic logic [7:0] method_char(input logic [3:0] idx);
        case (idx)
            4'd0:    return 8'h67;
            4'd1:    return 8'h65;
            4'd2:    return 8'h74;
            default: return CHAR_NUL;
        endcase
    endfunction

    // "http/1.1"
    function automatic logic [7:0] version_char(input logic [3:0] idx);
        case (idx)
            4'd0:    return 8'h68;
            4'd1:    return 8'h74;
            4'd2:    return 8'h74;
            4'd3:    return 8'h70;
            4'd4:    return 8'h2F;
            4'd5:    return 8'h31;
            4'd6:    return 8'h2E;
            4'd7:    return 8'h31;
            default: return CHAR_NUL;
        endcase
    endfunction

    // "host:"
    function automatic logic [7:0] host_char(input logic [3:0] idx);
        case (idx)
            4'd0:    return 8'h68;
            4'd1:    return 8'h6F;
            4'd2:    return 8'h73;
            4'd3:    return 8'h74;
            4'd4:    return 8'h3A;
            default: return CHAR_NUL;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/http_request_head_parser_unit.sv =====
// Top level: byte-serial HTTP/1.1 request head parser with one verdict per byte
//
//   channel | direction | payload    | handshake
//   --------+-----------+------------+------------------------------
//   req     | in        | hrhp_in_t  | req_valid / req_ready
//   rsp     | out       | hrhp_out_t | rsp_valid / rsp_ready
//   cfg     | in        | 16 bits    | cfg_we, no wait, no read-back
//
// One byte per clock sustained while rsp is drained; the verdict appears in the cycle after
// the byte is taken, from the output register. The parser state updates in the same cycle
// as the byte is taken. req_ready stays high while the output register is empty
// or being drained, so a stalled rsp side holds at most one result.
// rst_n clears the parser and sets the size limit to 4096.
`default_nettype none

module http_request_head_parser_unit
    import hrhp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire hrhp_in_t  req_data,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output hrhp_out_t      rsp_data,
    input  wire logic      cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    // Parser state
    logic        phase_reg,   phase_next;
    logic [3:0]  sub_reg,     sub_next;
    logic [3:0]  mcnt_reg,    mcnt_next;
    logic        cr_reg,      cr_next;
    logic        fail_reg,    fail_next;
    logic        zero_reg,    zero_next;
    logic [15:0] count_reg,   count_next;
    logic [1:0]  final_reg,   final_next;
    logic [15:0] max_reg;

    // Output stage
    logic        rsp_valid_reg;
    hrhp_out_t   rsp_reg;
    logic        host_next;

    logic        take;
    logic [7:0]  c;
    logic [7:0]  lc;
    logic [3:0]  sub_base;
    logic [3:0]  mcnt_base;
    logic [3:0]  vidx;
    logic [3:0]  hidx;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign take      = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // State as seen by this byte, after an optional clear
    assign sub_base  = req_data.new_request ? SUB_START : sub_reg;
    assign mcnt_base = req_data.new_request ? 4'd0 : mcnt_reg;

    assign c    = req_data.in_byte;
    assign lc   = lower_of(c);
    assign vidx = (sub_base == SUB_SKIP2) ? 4'd0 : mcnt_base;
    assign hidx = (sub_base == SUB_START) ? 4'd0 : mcnt_base;

    // Advance the parser by one byte
    always_comb
    begin
        phase_next = phase_reg;
        sub_next   = sub_reg;
        mcnt_next  = mcnt_reg;
        cr_next    = cr_reg;
        fail_next  = fail_reg;
        zero_next  = zero_reg;
        count_next = count_reg;
        final_next = final_reg;
        host_next  = 1'b0;

        if (req_data.new_request)
        begin
            phase_next = PHASE_REQUEST;
            sub_next   = SUB_START;
            mcnt_next  = 4'd0;
            cr_next    = 1'b0;
            fail_next  = 1'b0;
            zero_next  = 1'b0;
            count_next = 16'd0;
            final_next = VERDICT_INCOMPLETE;
        end

        if (final_next == VERDICT_INCOMPLETE)
        begin
            if (count_next >= max_reg)
            begin
                final_next = VERDICT_OVERFLOW;
            end
            else
            begin
                count_next = count_next + 16'd1;
                if (cr_next)
                begin
                    if (c != CHAR_LF)
                    begin
                        final_next = VERDICT_BAD;
                    end
                    else if (phase_next == PHASE_REQUEST)
                    begin
                        if (!fail_next && sub_next == SUB_VERSION
                            && mcnt_next == VERSION_LEN)
                        begin
                            sub_next   = SUB_START;
                            mcnt_next  = 4'd0;
                            cr_next    = 1'b0;
                            fail_next  = 1'b0;
                            zero_next  = 1'b0;
                            phase_next = PHASE_HEADER;
                        end
                        else
                        begin
                            final_next = VERDICT_BAD;
                        end
                    end
                    else if (sub_next == SUB_START)
                    begin
                        final_next = VERDICT_GET;
                    end
                    else
                    begin
                        sub_next  = SUB_START;
                        mcnt_next = 4'd0;
                        cr_next   = 1'b0;
                        fail_next = 1'b0;
                        zero_next = 1'b0;
                    end
                end
                else if (c == CHAR_CR)
                begin
                    cr_next = 1'b1;
                end
                else if (c == CHAR_LF)
                begin
                    final_next = VERDICT_BAD;
                end
                else if (zero_next)
                begin
                    // ignore content until the line ends
                end
                else if (c == CHAR_NUL)
                begin
                    zero_next = 1'b1;
                end
                else if (phase_next == PHASE_REQUEST)
                begin
                    // Request line: method, blanks, URL, blanks, version
                    case (sub_next)
                        SUB_METHOD:
                        begin
                            if (is_blank(c))
                            begin
                                if (mcnt_next != METHOD_LEN)
                                    fail_next = 1'b1;
                                sub_next = SUB_SKIP1;
                            end
                            else if (mcnt_next < METHOD_LEN && lc == method_char(mcnt_next))
                                mcnt_next = mcnt_next + 4'd1;
                            else
                                fail_next = 1'b1;
                        end
                        SUB_SKIP1:
                        begin
                            if (!is_blank(c))
                                sub_next = SUB_URL;
                        end
                        SUB_URL:
                        begin
                            if (is_blank(c))
                                sub_next = SUB_SKIP2;
                        end
                        default:
                        begin
                            if (!(sub_next == SUB_SKIP2 && is_blank(c)))
                            begin
                                sub_next  = (sub_next == SUB_SKIP2) ? SUB_VERSION : sub_next;
                                mcnt_next = vidx;
                                if (vidx < VERSION_LEN && lc == version_char(vidx))
                                    mcnt_next = vidx + 4'd1;
                                else
                                    fail_next = 1'b1;
                            end
                        end
                    endcase
                end
                else
                begin
                    // Header line: spot the Host prefix and flag its value
                    case (sub_next)
                        SUB_START, SUB_PREFIX:
                        begin
                            mcnt_next = hidx;
                            if (hidx < HOST_LEN && lc == host_char(hidx))
                            begin
                                mcnt_next = hidx + 4'd1;
                                sub_next  = (hidx + 4'd1 == HOST_LEN) ? SUB_HOSTSKIP
                                                                      : SUB_PREFIX;
                            end
                            else
                            begin
                                sub_next = SUB_OTHER;
                            end
                        end
                        SUB_HOSTSKIP:
                        begin
                            if (!is_blank(c))
                            begin
                                sub_next  = SUB_HOSTVAL;
                                host_next = 1'b1;
                            end
                        end
                        SUB_HOSTVAL:
                        begin
                            host_next = 1'b1;
                        end
                        default:
                        begin
                            host_next = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    // Hold the size limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_reg <= MAX_BYTES_RESET;
        else if (cfg_we)
            max_reg <= cfg_wdata;
    end

    // Update parser state on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_REQUEST;
            sub_reg   <= SUB_START;
            mcnt_reg  <= 4'd0;
            cr_reg    <= 1'b0;
            fail_reg  <= 1'b0;
            zero_reg  <= 1'b0;
            count_reg <= 16'd0;
            final_reg <= VERDICT_INCOMPLETE;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            sub_reg   <= sub_next;
            mcnt_reg  <= mcnt_next;
            cr_reg    <= cr_next;
            fail_reg  <= fail_next;
            zero_reg  <= zero_next;
            count_reg <= count_next;
            final_reg <= final_next;
        end
    end

    // Output valid: set on accept, drop when drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (take)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg.verdict    <= final_next;
            rsp_reg.host_valid <= host_next;
            rsp_reg.host_byte  <= c;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hrhp_checker.sv =====
// Checker: port-level properties of the request head parser, bound to the top level
`default_nettype none

module hrhp_checker
    import hrhp_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      req_valid,
    input wire logic      req_ready,
    input wire logic      rsp_valid,
    input wire logic      rsp_ready,
    input wire hrhp_out_t rsp_data
);

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result changed");

    // Every accepted transaction yields a result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("accepted byte produced no result");

    // An empty output register never blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("input stalled with empty output");

    // Host bytes are flagged only while the request is still open
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.host_valid |-> rsp_data.verdict == VERDICT_INCOMPLETE)
        else $error("host byte flagged after final verdict");

endmodule

bind http_request_head_parser_unit hrhp_checker u_hrhp_checker (.*);

`default_nettype wire

// ===== test/http_request_head_parser_unit_test.sv =====
// Testbench for the byte-serial HTTP request head parser: predicted verdicts, random traffic
`default_nettype none

module http_request_head_parser_unit_test;
    import hrhp_pkg::*;

    // Match texts, lower case, first character in the top byte
    localparam logic [23:0] METHOD_STR  = "get";
    localparam logic [63:0] VERSION_STR = "http/1.1";
    localparam logic [39:0] HOST_STR    = "host:";

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            req_valid = 1'b0;
    logic            req_ready;
    hrhp_in_t        req_data = '0;
    logic            rsp_valid;
    logic            rsp_ready = 1'b0;
    hrhp_out_t       rsp_data;
    logic            cfg_we = 1'b0;
    logic [15:0]     cfg_wdata = '0;

    // Predicted parser state
    logic [15:0]     size_limit;
    logic            in_headers;
    logic [3:0]      line_state;
    logic [3:0]      match_len;
    logic            cr_seen;
    logic            line_broken;
    logic            nul_seen;
    logic [15:0]     byte_count;
    logic [1:0]      verdict_held;

    hrhp_out_t       verdicts_due[$];
    logic [7:0]      req_bytes[$];
    int              error_count = 0;
    bit              req_idle_on = 1'b1;
    bit              rsp_idle_on = 1'b1;
    int              rsp_hold_cycles = 0;

    http_request_head_parser_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [7:0] to_lower_char(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
            return c + 8'd32;
        return c;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SP) || (c == CHAR_TAB);
    endfunction

    function automatic logic [7:0] text_char(input logic [63:0] text, input int len,
                                             input int idx);
        return text[8 * (len - 1 - idx) +: 8];
    endfunction

    function automatic void clear_line_state();
        line_state  = SUB_START;
        match_len   = 4'd0;
        cr_seen     = 1'b0;
        line_broken = 1'b0;
        nul_seen    = 1'b0;
    endfunction

    function automatic void clear_request_state();
        clear_line_state();
        in_headers   = PHASE_REQUEST;
        byte_count   = 16'd0;
        verdict_held = VERDICT_INCOMPLETE;
    endfunction

    // Advance the request line matcher by one meaningful byte
    function automatic void request_line_char(input logic [7:0] c);
        logic [7:0] lc;
        lc = to_lower_char(c);
        case (line_state)
            SUB_METHOD:
            begin
                if (is_space(c))
                begin
                    if (match_len != METHOD_LEN)
                        line_broken = 1'b1;
                    line_state = SUB_SKIP1;
                end
                else if (match_len < METHOD_LEN
                         && lc == text_char(64'(METHOD_STR), 3, int'(match_len)))
                    match_len = match_len + 4'd1;
                else
                    line_broken = 1'b1;
            end
            SUB_SKIP1:
            begin
                if (!is_space(c))
                    line_state = SUB_URL;
            end
            SUB_URL:
            begin
                if (is_space(c))
                    line_state = SUB_SKIP2;
            end
            default:
            begin
                if (!(line_state == SUB_SKIP2 && is_space(c)))
                begin
                    // first version byte is compared as it arrives
                    if (line_state == SUB_SKIP2)
                    begin
                        line_state = SUB_VERSION;
                        match_len  = 4'd0;
                    end
                    if (match_len < VERSION_LEN
                        && lc == text_char(VERSION_STR, 8, int'(match_len)))
                        match_len = match_len + 4'd1;
                    else
                        line_broken = 1'b1;
                end
            end
        endcase
    endfunction

    // Advance the header line matcher; return 1 for a Host value byte
    function automatic logic header_line_char(input logic [7:0] c);
        logic [7:0] lc;
        lc = to_lower_char(c);
        case (line_state)
            SUB_START, SUB_PREFIX:
            begin
                if (line_state == SUB_START)
                    match_len = 4'd0;
                if (match_len < HOST_LEN
                    && lc == text_char(64'(HOST_STR), 5, int'(match_len)))
                begin
                    match_len  = match_len + 4'd1;
                    line_state = (match_len == HOST_LEN) ? SUB_HOSTSKIP : SUB_PREFIX;
                end
                else
                    line_state = SUB_OTHER;
                return 1'b0;
            end
            SUB_HOSTSKIP:
            begin
                if (is_space(c))
                    return 1'b0;
                line_state = SUB_HOSTVAL;
                return 1'b1;
            end
            SUB_HOSTVAL:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // Work out the verdict for one accepted byte and advance the predicted state
    function automatic hrhp_out_t parse_byte(input hrhp_in_t item);
        hrhp_out_t  res;
        logic [7:0] c;
        logic       host;
        c    = item.in_byte;
        host = 1'b0;
        if (item.new_request)
            clear_request_state();
        if (verdict_held == VERDICT_INCOMPLETE)
        begin
            if (byte_count >= size_limit)
                verdict_held = VERDICT_OVERFLOW;
            else
            begin
                byte_count = byte_count + 16'd1;
                if (cr_seen)
                begin
                    if (c != CHAR_LF)
                        verdict_held = VERDICT_BAD;
                    else if (in_headers == PHASE_REQUEST)
                    begin
                        if (!line_broken && line_state == SUB_VERSION
                            && match_len == VERSION_LEN)
                        begin
                            clear_line_state();
                            in_headers = PHASE_HEADER;
                        end
                        else
                            verdict_held = VERDICT_BAD;
                    end
                    else if (line_state == SUB_START)
                        verdict_held = VERDICT_GET;
                    else
                        clear_line_state();
                end
                else if (c == CHAR_CR)
                    cr_seen = 1'b1;
                else if (c == CHAR_LF)
                    verdict_held = VERDICT_BAD;
                else if (nul_seen)
                    ;  // rest of the line carries no content
                else if (c == CHAR_NUL)
                    nul_seen = 1'b1;
                else if (in_headers == PHASE_REQUEST)
                    request_line_char(c);
                else
                    host = header_line_char(c);
            end
        end
        res.verdict    = verdict_held;
        res.host_valid = host;
        res.host_byte  = c;
        return res;
    endfunction

    // ---------------------------------------------------------------- scoreboard

    // Predict on each accepted transaction, check each result against the oldest
    always @(posedge clk)
    begin : scoreboard
        hrhp_out_t want;
        if (!rst_n)
        begin
            size_limit = MAX_BYTES_RESET;
            clear_request_state();
        end
        else
        begin
            if (cfg_we)
                size_limit = cfg_wdata;
            if (rsp_valid && rsp_ready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %h", $time, rsp_data);
                    error_count++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (rsp_data.verdict !== want.verdict)
                    begin
                        $display("%0t: verdict mismatch, expected %0d, got %0d",
                                 $time, want.verdict, rsp_data.verdict);
                        error_count++;
                    end
                    if (rsp_data.host_valid !== want.host_valid)
                    begin
                        $display("%0t: host_valid mismatch, expected %0d, got %0d",
                                 $time, want.host_valid, rsp_data.host_valid);
                        error_count++;
                    end
                    if (rsp_data.host_byte !== want.host_byte)
                    begin
                        $display("%0t: host_byte mismatch, expected %h, got %h",
                                 $time, want.host_byte, rsp_data.host_byte);
                        error_count++;
                    end
                end
            end
            if (req_valid && req_ready)
                verdicts_due.push_back(parse_byte(req_data));
        end
    end

    // ---------------------------------------------------------------- drivers

    function automatic int draw_gap(input bit idle_on);
        if (!idle_on || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Drain side: random stalls, plus a long hold-off when one is requested
    initial
    begin : receiver
        int gap;
        int hold;
        forever
        begin
            if (rsp_hold_cycles > 0)
            begin
                hold = rsp_hold_cycles;
                rsp_hold_cycles = 0;
                rsp_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            gap = draw_gap(rsp_idle_on);
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    // Offer one byte and hold it until the transaction completes
    task automatic send_byte(input logic [7:0] b, input logic restart);
        int gap;
        gap = draw_gap(req_idle_on);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid            <= 1'b1;
        req_data.in_byte     <= b;
        req_data.new_request <= restart;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic send_line(input string s, input logic restart);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], restart && i == 0);
        send_byte(CHAR_CR, restart && s.len() == 0);
        send_byte(CHAR_LF, 1'b0);
    endtask

    // Stop offering and wait until every predicted verdict has come back
    task automatic finish_burst();
        req_valid <= 1'b0;
        @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_size_limit(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // ---------------------------------------------------------------- request builder

    function automatic void push_word(input logic [63:0] text, input int len);
        int i;
        logic [7:0] c;
        for (i = 0; i < len; i++)
        begin
            c = text_char(text, len, i);
            if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1)
                c = c - 8'd32;
            req_bytes.push_back(c);
        end
    endfunction

    function automatic void push_blanks(input int lo, input int hi);
        int i;
        int n;
        n = $urandom_range(lo, hi);
        for (i = 0; i < n; i++)
            req_bytes.push_back($urandom_range(0, 1) ? CHAR_SP : CHAR_TAB);
    endfunction

    function automatic void push_printable(input int lo, input int hi);
        int i;
        int n;
        n = $urandom_range(lo, hi);
        for (i = 0; i < n; i++)
            req_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
    endfunction

    function automatic void push_crlf();
        req_bytes.push_back(CHAR_CR);
        req_bytes.push_back(CHAR_LF);
    endfunction

    // Fill req_bytes with a mostly well-formed request, sometimes damaged or pure noise
    function automatic void build_request();
        int i;
        int n;
        int h;
        int pos;
        req_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++)
                req_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        push_word(64'(METHOD_STR), 3);
        push_blanks(1, 3);
        req_bytes.push_back(8'h2F);
        push_printable(0, 6);
        push_blanks(1, 3);
        push_word(VERSION_STR, 8);
        push_crlf();
        h = $urandom_range(0, 3);
        for (i = 0; i < h; i++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                push_word(64'(HOST_STR), 5);
                push_blanks(0, 2);
                push_printable(1, 6);
            end
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n) req_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
                req_bytes.push_back(8'h3A);
                push_blanks(0, 1);
                push_printable(0, 8);
            end
            push_crlf();
        end
        // end the head with a blank line, or a line opened by a zero byte
        if ($urandom_range(0, 5) == 0)
            req_bytes.push_back(CHAR_NUL);
        push_crlf();
        // damage some requests
        if ($urandom_range(0, 3) == 0)
        begin
            pos = $urandom_range(0, req_bytes.size() - 1);
            case ($urandom_range(0, 3))
                0: req_bytes[pos] = 8'($urandom_range(0, 255));
                1: req_bytes.insert(pos, CHAR_NUL);
                2: req_bytes.delete(pos);
                default:
                begin
                    while (req_bytes.size() > pos + 1)
                        void'(req_bytes.pop_back());
                end
            endcase
        end
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
        // mixed case and tab separators, Host value flagged
        send_line("gEt\t/ HTTP/1.1", 1'b1);
        send_line("hOsT:\tz", 1'b0);
        // a line opened by a zero byte ends the head
        send_byte(CHAR_NUL, 1'b0);
        send_byte(CHAR_CR, 1'b0);
        send_byte(CHAR_LF, 1'b0);
        // final verdict repeats, byte ignored
        send_byte(8'hFF, 1'b0);
        // bare LF
        send_byte(CHAR_LF, 1'b1);
        // CR followed by something other than LF
        send_byte(CHAR_CR, 1'b1);
        send_byte(8'h80, 1'b0);
        // zero byte inside the request line hides the version
        send_byte(8'h47, 1'b1);
        send_byte(8'h45, 1'b0);
        send_byte(8'h54, 1'b0);
        send_byte(CHAR_SP, 1'b0);
        send_byte(8'h2F, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(CHAR_NUL, 1'b0);
        send_line(" HTTP/1.1", 1'b0);
        finish_burst();
    endtask

    task automatic test_size_limit();
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
        // zero limit overflows on the first byte
        set_size_limit(16'd0);
        send_byte(8'h47, 1'b1);
        finish_burst();
        set_size_limit(16'd1);
        send_byte(8'h47, 1'b1);
        send_byte(8'h45, 1'b0);
        finish_burst();
        set_size_limit(16'hFFFF);
        send_line("GET /max HTTP/1.1", 1'b1);
        send_line("", 1'b0);
        finish_burst();
        // overflow in the middle of the request line
        set_size_limit(16'd12);
        send_line("GET / HTTP/1.1", 1'b1);
        finish_burst();
        set_size_limit(MAX_BYTES_RESET);
    endtask

    task automatic test_backpressure();
        req_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
        rsp_hold_cycles = 64;
        send_line("GET /stall HTTP/1.1", 1'b1);
        send_line("Host: q", 1'b0);
        send_line("", 1'b0);
        finish_burst();
    endtask

    task automatic test_random_requests();
        int sent;
        int i;
        int extra;
        logic restart;
        logic [15:0] limit;
        sent = 0;
        while (sent < 270)
        begin
            // pause, drain, and sometimes move the size limit
            if ($urandom_range(0, 7) == 0)
            begin
                finish_burst();
                case ($urandom_range(0, 3))
                    0: limit = 16'($urandom_range(1, 40));
                    1: limit = 16'hFFFF;
                    default: limit = MAX_BYTES_RESET;
                endcase
                set_size_limit(limit);
            end
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
            build_request();
            for (i = 0; i < req_bytes.size(); i++)
            begin
                if (i == 0)
                    restart = ($urandom_range(0, 15) != 0);
                else
                    restart = ($urandom_range(0, 63) == 0);
                send_byte(req_bytes[i], restart);
            end
            sent += req_bytes.size();
            // trailing bytes, mostly ignored after a final verdict
            extra = $urandom_range(0, 2);
            repeat (extra) send_byte(8'($urandom_range(0, 255)), 1'b0);
            sent += extra;
        end
        finish_burst();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_size_limit();
        test_backpressure();
        test_random_requests();
        finish_burst();
        repeat (4) @(posedge clk);
        if (verdicts_due.size() != 0)
        begin
            $display("%0t: %0d verdicts never arrived, expected 0 pending, got %0d",
                     $time, verdicts_due.size(), verdicts_due.size());
            error_count++;
        end
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
